@@ hdl/dnf_pkg.sv @@
// shared types, constants and the microcode table of the downslope neighbor finder
package dnf_pkg;

    // field widths
    localparam int ROW_W   = 8;
    localparam int COL_W   = 8;
    localparam int ELEV_W  = 32;
    localparam int AIDX_W  = 10;
    localparam int PMASK_W = 4;
    localparam int REQ_W   = 2;
    localparam int STAT_W  = 3;
    localparam int CNT_W   = 3;
    localparam int BOUND_W = 9;

    // store sizes
    localparam int GRID_ROWS  = 256;
    localparam int GRID_COLS  = 256;
    localparam int GRID_DEPTH = GRID_ROWS * GRID_COLS;
    localparam int ACT_DEPTH  = 1024;
    localparam int GRID_AW    = ROW_W + COL_W;

    localparam logic [BOUND_W-1:0] ROW_LIMIT = BOUND_W'(GRID_ROWS);
    localparam logic [BOUND_W-1:0] COL_LIMIT = BOUND_W'(GRID_COLS);

    // request kinds
    localparam logic [REQ_W-1:0] REQ_GRID  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ENTRY = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 3'd0;
    localparam logic [STAT_W-1:0] STAT_SOUTH = 3'd1;
    localparam logic [STAT_W-1:0] STAT_NORTH = 3'd2;
    localparam logic [STAT_W-1:0] STAT_WEST  = 3'd3;
    localparam logic [STAT_W-1:0] STAT_EAST  = 3'd4;

    // configuration register indexes
    localparam logic REG_NUM_ROWS = 1'b0;
    localparam logic REG_NUM_COLS = 1'b1;

    // parent mask bits
    localparam logic [PMASK_W-1:0] BIT_EAST  = 4'(1 << 0);
    localparam logic [PMASK_W-1:0] BIT_SOUTH = 4'(1 << 1);
    localparam logic [PMASK_W-1:0] BIT_WEST  = 4'(1 << 2);
    localparam logic [PMASK_W-1:0] BIT_NORTH = 4'(1 << 3);

    // neighbor visiting order
    localparam logic [1:0] DIR_NORTH = 2'd0;
    localparam logic [1:0] DIR_SOUTH = 2'd1;
    localparam logic [1:0] DIR_WEST  = 2'd2;
    localparam logic [1:0] DIR_EAST  = 2'd3;

    // microcode step addresses
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_IDLE    = 4'd0;
    localparam logic [STEP_W-1:0] STEP_CHECK   = 4'd1;
    localparam logic [STEP_W-1:0] STEP_LOOK    = 4'd2;
    localparam logic [STEP_W-1:0] STEP_GRID    = 4'd3;
    localparam logic [STEP_W-1:0] STEP_ACT     = 4'd4;
    localparam logic [STEP_W-1:0] STEP_NEXT    = 4'd5;
    localparam logic [STEP_W-1:0] STEP_SUMMARY = 4'd6;
    localparam logic [STEP_W-1:0] STEP_EMIT    = 4'd7;
    localparam logic [STEP_W-1:0] STEP_DONE    = 4'd8;
    localparam logic [STEP_W-1:0] STEP_EMPTY   = 4'd9;
    localparam logic [STEP_W-1:0] STEP_STATUS  = 4'd10;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_CHECK,
        OP_READ_GRID,
        OP_HIT_GRID,
        OP_HIT_ACT,
        OP_NEXT,
        OP_EMIT_HIT,
        OP_EMIT_EMPTY,
        OP_EMIT_STATUS
    } dnf_op_t;

    // jump conditions
    typedef enum logic [3:0] {
        C_NEXT,
        C_ALWAYS,
        C_NOT_QUERY,
        C_OFF_GRID,
        C_PARENT,
        C_NOT_ACTIVE,
        C_MORE_K,
        C_NO_HITS,
        C_MORE_HITS
    } dnf_cond_t;

    // one control word
    typedef struct packed {
        dnf_op_t            op;
        dnf_cond_t          cond;
        logic               wait_out;
        logic [STEP_W-1:0]  target;
    } dnf_uword_t;

    // command from sequencer to datapath
    typedef struct packed {
        dnf_op_t op;
        logic    fire;
    } dnf_cmd_t;

    // condition flags from datapath to sequencer
    typedef struct packed {
        logic is_query;
        logic off_grid;
        logic parent;
        logic active;
        logic more_k;
        logic no_hits;
        logic more_hits;
        logic out_busy;
    } dnf_flags_t;

    // microcode rom
    function automatic dnf_uword_t dnf_ucode(input logic [STEP_W-1:0] step);
        dnf_uword_t w;
        unique case (step)
            STEP_IDLE:    w = '{OP_ACCEPT,      C_NOT_QUERY,  1'b0, STEP_IDLE};
            STEP_CHECK:   w = '{OP_CHECK,       C_OFF_GRID,   1'b0, STEP_STATUS};
            STEP_LOOK:    w = '{OP_READ_GRID,   C_PARENT,     1'b0, STEP_NEXT};
            STEP_GRID:    w = '{OP_HIT_GRID,    C_NOT_ACTIVE, 1'b0, STEP_NEXT};
            STEP_ACT:     w = '{OP_HIT_ACT,     C_NEXT,       1'b0, STEP_IDLE};
            STEP_NEXT:    w = '{OP_NEXT,        C_MORE_K,     1'b0, STEP_LOOK};
            STEP_SUMMARY: w = '{OP_NONE,        C_NO_HITS,    1'b0, STEP_EMPTY};
            STEP_EMIT:    w = '{OP_EMIT_HIT,    C_MORE_HITS,  1'b1, STEP_EMIT};
            STEP_DONE:    w = '{OP_NONE,        C_ALWAYS,     1'b0, STEP_IDLE};
            STEP_EMPTY:   w = '{OP_EMIT_EMPTY,  C_ALWAYS,     1'b1, STEP_IDLE};
            STEP_STATUS:  w = '{OP_EMIT_STATUS, C_ALWAYS,     1'b1, STEP_IDLE};
            default:      w = '{OP_NONE,        C_ALWAYS,     1'b0, STEP_IDLE};
        endcase
        return w;
    endfunction

    // parent mask bit of a direction
    function automatic logic [PMASK_W-1:0] dnf_dir_bit(input logic [1:0] dir);
        logic [PMASK_W-1:0] b;
        unique case (dir)
            DIR_NORTH: b = BIT_NORTH;
            DIR_SOUTH: b = BIT_SOUTH;
            DIR_WEST:  b = BIT_WEST;
            default:   b = BIT_EAST;
        endcase
        return b;
    endfunction

endpackage

@@ hdl/dnf_ram.sv @@
// single-port ram with registered read data
module dnf_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write or read one entry
    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/dnf_sequencer.sv @@
// microcode sequencer: step counter, control rom and jump logic
module dnf_sequencer
    import dnf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  dnf_flags_t flags,
    output dnf_cmd_t   cmd,
    output logic       s_tready
);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    dnf_uword_t        uw;
    logic              stall;
    logic              take_jump;

    // fetch the control word
    assign uw = dnf_ucode(step_reg);

    // hold the step while waiting on either channel
    assign stall = ((uw.op == OP_ACCEPT) && !s_tvalid) || (uw.wait_out && flags.out_busy);

    assign cmd.op   = uw.op;
    assign cmd.fire = !stall;
    assign s_tready = (uw.op == OP_ACCEPT);

    // jump condition
    always_comb begin
        case (uw.cond)
            C_NEXT:       take_jump = 1'b0;
            C_ALWAYS:     take_jump = 1'b1;
            C_NOT_QUERY:  take_jump = !flags.is_query;
            C_OFF_GRID:   take_jump = flags.off_grid;
            C_PARENT:     take_jump = flags.parent;
            C_NOT_ACTIVE: take_jump = !flags.active;
            C_MORE_K:     take_jump = flags.more_k;
            C_NO_HITS:    take_jump = flags.no_hits;
            C_MORE_HITS:  take_jump = flags.more_hits;
            default:      take_jump = 1'b0;
        endcase
    end

    // next step address
    always_comb begin
        if (stall) begin
            step_next = step_reg;
        end else if (take_jump) begin
            step_next = uw.target;
        end else begin
            step_next = step_reg + STEP_W'(1);
        end
    end

    // step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

@@ hdl/dnf_datapath.sv @@
// datapath: grid and active-list stores, neighbor compare, hit buffer, result register
module dnf_datapath
    import dnf_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  dnf_cmd_t            cmd,
    output dnf_flags_t          flags,
    input  logic [63:0]         s_tdata,
    input  logic [REQ_W-1:0]    s_tuser,
    input  logic                cfg_we,
    input  logic                cfg_addr,
    input  logic [BOUND_W-1:0]  cfg_wdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [55:0]         m_tdata,
    output logic                m_tuser,
    output logic                m_tlast
);

    // input fields
    logic [ROW_W-1:0]          in_row;
    logic [COL_W-1:0]          in_col;
    logic signed [ELEV_W-1:0]  in_elev;
    logic [AIDX_W-1:0]         in_aidx;
    logic [PMASK_W-1:0]        in_pmask;

    assign in_row   = s_tdata[7:0];
    assign in_col   = s_tdata[15:8];
    assign in_elev  = s_tdata[47:16];
    assign in_aidx  = s_tdata[57:48];
    assign in_pmask = s_tdata[61:58];

    // control state
    logic [BOUND_W-1:0] num_rows_reg;
    logic [BOUND_W-1:0] num_cols_reg;
    logic [1:0]         k_reg;
    logic [CNT_W-1:0]   hit_cnt_reg;
    logic [1:0]         out_j_reg;
    logic               m_valid_reg;

    // payload state
    logic [ROW_W-1:0]          cen_row_reg;
    logic [COL_W-1:0]          cen_col_reg;
    logic signed [ELEV_W-1:0]  cen_elev_reg;
    logic [PMASK_W-1:0]        pmask_reg;
    logic [STAT_W-1:0]         status_reg;
    logic [ROW_W-1:0]          hit_row_reg  [4];
    logic [COL_W-1:0]          hit_col_reg  [4];
    logic signed [ELEV_W-1:0]  hit_elev_reg [4];
    logic [STAT_W-1:0]         out_status_reg;
    logic                      out_nvalid_reg;
    logic [ROW_W-1:0]          out_row_reg;
    logic [COL_W-1:0]          out_col_reg;
    logic signed [ELEV_W-1:0]  out_elev_reg;
    logic [CNT_W-1:0]          out_count_reg;
    logic                      out_last_reg;

    // operation strobes
    logic accept;
    logic do_check;
    logic do_read;
    logic do_hit_grid;
    logic do_hit_act;
    logic do_next;
    logic do_emit_hit;
    logic do_emit_other;

    assign accept        = cmd.fire && (cmd.op == OP_ACCEPT);
    assign do_check      = cmd.fire && (cmd.op == OP_CHECK);
    assign do_read       = cmd.fire && (cmd.op == OP_READ_GRID);
    assign do_hit_grid   = cmd.fire && (cmd.op == OP_HIT_GRID);
    assign do_hit_act    = cmd.fire && (cmd.op == OP_HIT_ACT);
    assign do_next       = cmd.fire && (cmd.op == OP_NEXT);
    assign do_emit_hit   = cmd.fire && (cmd.op == OP_EMIT_HIT);
    assign do_emit_other = cmd.fire && ((cmd.op == OP_EMIT_EMPTY) ||
                                        (cmd.op == OP_EMIT_STATUS));

    // bounds clipped to the grid size
    logic [BOUND_W-1:0] row_bound;
    logic [BOUND_W-1:0] col_bound;
    logic [STAT_W-1:0]  chk_status;

    assign row_bound = (num_rows_reg > ROW_LIMIT) ? ROW_LIMIT : num_rows_reg;
    assign col_bound = (num_cols_reg > COL_LIMIT) ? COL_LIMIT : num_cols_reg;

    // off-grid check in south, north, west, east order
    always_comb begin
        if (cen_row_reg == '0) begin
            chk_status = STAT_SOUTH;
        end else if (({1'b0, cen_row_reg} + BOUND_W'(1)) >= row_bound) begin
            chk_status = STAT_NORTH;
        end else if (cen_col_reg == '0) begin
            chk_status = STAT_WEST;
        end else if (({1'b0, cen_col_reg} + BOUND_W'(1)) >= col_bound) begin
            chk_status = STAT_EAST;
        end else begin
            chk_status = STAT_OK;
        end
    end

    // neighbor position for the current direction
    logic [ROW_W-1:0] nbr_row;
    logic [COL_W-1:0] nbr_col;

    always_comb begin
        nbr_row = cen_row_reg;
        nbr_col = cen_col_reg;
        unique case (k_reg)
            DIR_NORTH: nbr_row = cen_row_reg + ROW_W'(1);
            DIR_SOUTH: nbr_row = cen_row_reg - ROW_W'(1);
            DIR_WEST:  nbr_col = cen_col_reg - COL_W'(1);
            default:   nbr_col = cen_col_reg + COL_W'(1);
        endcase
    end

    // grid store: active index above elevation
    logic                       grid_en;
    logic                       grid_we;
    logic [GRID_AW-1:0]         grid_addr;
    logic [AIDX_W+ELEV_W-1:0]   grid_rdata;
    logic signed [ELEV_W-1:0]   grid_elev;
    logic [AIDX_W-1:0]          grid_aidx;

    assign grid_we   = accept && (s_tuser == REQ_GRID);
    assign grid_en   = grid_we || do_read;
    assign grid_addr = grid_we ? {in_row, in_col} : {nbr_row, nbr_col};
    assign grid_elev = grid_rdata[ELEV_W-1:0];
    assign grid_aidx = grid_rdata[AIDX_W+ELEV_W-1:ELEV_W];

    dnf_ram #(
        .DEPTH (GRID_DEPTH),
        .WIDTH (AIDX_W + ELEV_W)
    ) u_grid_ram (
        .aclk  (aclk),
        .en    (grid_en),
        .we    (grid_we),
        .addr  (grid_addr),
        .wdata ({in_aidx, in_elev}),
        .rdata (grid_rdata)
    );

    // active-list store
    logic                       act_en;
    logic                       act_we;
    logic [AIDX_W-1:0]          act_addr;
    logic [ELEV_W-1:0]          act_rdata;

    assign act_we   = accept && (s_tuser == REQ_ENTRY);
    assign act_en   = act_we || do_hit_grid;
    assign act_addr = act_we ? in_aidx : grid_aidx;

    dnf_ram #(
        .DEPTH (ACT_DEPTH),
        .WIDTH (ELEV_W)
    ) u_act_ram (
        .aclk  (aclk),
        .en    (act_en),
        .we    (act_we),
        .addr  (act_addr),
        .wdata (in_elev),
        .rdata (act_rdata)
    );

    // effective elevation and strict downslope test
    logic signed [ELEV_W-1:0] eff_elev;
    logic                     record_hit;

    assign eff_elev   = do_hit_act ? $signed(act_rdata) : grid_elev;
    assign record_hit = (do_hit_act || (do_hit_grid && (grid_aidx == '0))) &&
                        (cen_elev_reg > eff_elev);

    // result selection
    logic [CNT_W-1:0] out_j_ext;
    logic             hit_is_last;

    assign out_j_ext   = {1'b0, out_j_reg} + CNT_W'(1);
    assign hit_is_last = (out_j_ext == hit_cnt_reg);

    // flags back to the sequencer
    assign flags.is_query  = (s_tuser == REQ_QUERY);
    assign flags.off_grid  = (chk_status != STAT_OK);
    assign flags.parent    = ((pmask_reg & dnf_dir_bit(k_reg)) != '0);
    assign flags.active    = (grid_aidx != '0);
    assign flags.more_k    = (k_reg != DIR_EAST);
    assign flags.no_hits   = (hit_cnt_reg == '0);
    assign flags.more_hits = !hit_is_last;
    assign flags.out_busy  = m_valid_reg && !m_tready;

    // control registers and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_rows_reg <= ROW_LIMIT;
            num_cols_reg <= COL_LIMIT;
            k_reg        <= DIR_NORTH;
            hit_cnt_reg  <= '0;
            out_j_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    REG_NUM_ROWS: num_rows_reg <= cfg_wdata;
                    default:      num_cols_reg <= cfg_wdata;
                endcase
            end
            if (do_check) begin
                k_reg       <= DIR_NORTH;
                hit_cnt_reg <= '0;
                out_j_reg   <= '0;
            end
            if (do_next) begin
                k_reg <= k_reg + 2'd1;
            end
            if (record_hit) begin
                hit_cnt_reg <= hit_cnt_reg + CNT_W'(1);
            end
            if (do_emit_hit) begin
                out_j_reg <= out_j_reg + 2'd1;
            end
            if (do_emit_hit || do_emit_other) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            cen_row_reg  <= in_row;
            cen_col_reg  <= in_col;
            cen_elev_reg <= in_elev;
            pmask_reg    <= in_pmask;
        end
        if (do_check) begin
            status_reg <= chk_status;
        end
        if (record_hit) begin
            hit_row_reg[hit_cnt_reg[1:0]]  <= nbr_row;
            hit_col_reg[hit_cnt_reg[1:0]]  <= nbr_col;
            hit_elev_reg[hit_cnt_reg[1:0]] <= eff_elev;
        end
        if (do_emit_hit) begin
            out_status_reg <= STAT_OK;
            out_nvalid_reg <= 1'b1;
            out_row_reg    <= hit_row_reg[out_j_reg];
            out_col_reg    <= hit_col_reg[out_j_reg];
            out_elev_reg   <= hit_elev_reg[out_j_reg];
            out_count_reg  <= hit_cnt_reg;
            out_last_reg   <= hit_is_last;
        end else if (do_emit_other) begin
            out_status_reg <= (cmd.op == OP_EMIT_STATUS) ? status_reg : STAT_OK;
            out_nvalid_reg <= 1'b0;
            out_row_reg    <= '0;
            out_col_reg    <= '0;
            out_elev_reg   <= '0;
            out_count_reg  <= '0;
            out_last_reg   <= 1'b1;
        end
    end

    // result channel
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, out_count_reg, out_elev_reg, out_col_reg, out_row_reg,
                       out_status_reg};
    assign m_tuser  = out_nvalid_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    // at most four neighbors can qualify
    a_hit_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        hit_cnt_reg <= CNT_W'(4))
        else $error("hit count above four");

    // a neighbor result carries ok status and a nonzero count
    a_nbr_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_nvalid_reg) |-> (out_count_reg != '0) && (out_status_reg == STAT_OK))
        else $error("neighbor result with bad count or status");

    // an off-grid result is the only and last result of its query
    a_status_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (out_status_reg != STAT_OK)) |-> (out_last_reg && !out_nvalid_reg))
        else $error("off-grid result not alone");

    // a result is only loaded once the previous one has left
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_emit_hit || do_emit_other) |-> (!m_valid_reg || m_tready))
        else $error("result register overwritten");
`endif

endmodule

@@ hdl/downslope_neighbor_finder.sv @@
// top level of the downslope neighbor finder
//
//  channel   direction  ports                         payload
//  s_        in         s_tvalid s_tready s_tdata     request: write grid, write entry, query
//                       s_tuser
//  m_        out        m_tvalid m_tready m_tdata     status, neighbor, count
//                       m_tuser m_tlast
//  cfg_      in         cfg_we cfg_addr cfg_wdata     num_rows (0), num_cols (1)
//
// a write is taken in the idle step; an off-grid query goes from the check step to the
// status step; otherwise each neighbor is a grid ram read, then an active-list ram read for
// active cells, one microcode step per cycle over single-port memories when not stalled.
// reset is synchronous, active low; the stores are not cleared.
// the result register lets the next request be taken while the last result waits;
// a stalled result channel holds the sequencer at its next emit step.
module downslope_neighbor_finder
    import dnf_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // row[7:0], col[15:8], elev[47:16], active_index[57:48], parent_mask[61:58]
    input  logic [63:0]         s_tdata,
    // req_type[1:0]
    input  logic [REQ_W-1:0]    s_tuser,
    input  logic                s_tvalid,
    output logic                s_tready,
    // status[2:0], nbr_row[10:3], nbr_col[18:11], nbr_elev[50:19], neighbor_count[53:51]
    output logic [55:0]         m_tdata,
    // neighbor_valid[0]
    output logic                m_tuser,
    output logic                m_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  logic                cfg_we,
    input  logic                cfg_addr,
    input  logic [BOUND_W-1:0]  cfg_wdata
);

    dnf_cmd_t   cmd;
    dnf_flags_t flags;

    // microcode control
    dnf_sequencer u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .flags    (flags),
        .cmd      (cmd),
        .s_tready (s_tready)
    );

    // stores, compare and result register
    dnf_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .flags     (flags),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

@@ dv/tb_downslope_neighbor_finder.sv @@
// testbench for downslope_neighbor_finder: random stream traffic checked against an in-bench predictor
`timescale 1ns / 100ps

module tb_downslope_neighbor_finder;
    import dnf_pkg::*;

    // request kind that the block ignores
    localparam logic [REQ_W-1:0] REQ_SKIP = 2'd3;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 30;
    localparam int NUM_PHASES    = 7;

    // one request as it travels on the input channel
    typedef struct packed {
        logic [REQ_W-1:0]   kind;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [ELEV_W-1:0]  elev;
        logic [AIDX_W-1:0]  aidx;
        logic [PMASK_W-1:0] pmask;
    } request_t;

    // one downslope result
    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic               nvalid;
        logic [ROW_W-1:0]   nrow;
        logic [COL_W-1:0]   ncol;
        logic [ELEV_W-1:0]  nelev;
        logic [CNT_W-1:0]   count;
        logic               last;
    } downslope_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    // row[7:0], col[15:8], elev[47:16], active_index[57:48], parent_mask[61:58]
    logic [63:0]         s_tdata   = '0;
    // req_type[1:0]
    logic [REQ_W-1:0]    s_tuser   = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    // status[2:0], nbr_row[10:3], nbr_col[18:11], nbr_elev[50:19], neighbor_count[53:51]
    logic [55:0]         m_tdata;
    // neighbor_valid[0]
    logic                m_tuser;
    logic                m_tlast;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic                cfg_we    = 1'b0;
    logic                cfg_addr  = REG_NUM_ROWS;
    logic [BOUND_W-1:0]  cfg_wdata = '0;

    downslope_neighbor_finder DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // predictor copy of the stores and the bounds
    logic [ELEV_W-1:0]  elev_mirror   [GRID_DEPTH];
    logic [AIDX_W-1:0]  index_mirror  [GRID_DEPTH];
    logic [ELEV_W-1:0]  active_mirror [ACT_DEPTH];
    logic [BOUND_W-1:0] row_bound = BOUND_W'(256);
    logic [BOUND_W-1:0] col_bound = BOUND_W'(256);

    // what the generator has loaded so far, in request order
    bit cell_loaded  [GRID_DEPTH];
    bit entry_loaded [ACT_DEPTH];

    request_t   request_q [$];
    downslope_t downslope_q [$];

    int err_count    = 0;
    int feed_count   = 0;
    int sent_count   = 0;
    int queries_sent = 0;
    int results_seen = 0;
    int hits_seen    = 0;
    int empty_seen   = 0;
    int off_seen     = 0;
    int hold_asked   = 0;

    int phase_rows [NUM_PHASES] = '{256, 10, 0, 1, 256, 3, 300};
    int phase_cols [NUM_PHASES] = '{256, 12, 511, 256, 1, 3, 40};
    int phase_feed [NUM_PHASES] = '{40, 40, 40, 40, 40, 40, 40};

    // off-grid check in the block's order: south, north, west, east
    function automatic logic [STAT_W-1:0] bound_status(input logic [ROW_W-1:0] r,
                                                       input logic [COL_W-1:0] c);
        int rb;
        int cb;
        rb = (row_bound > GRID_ROWS) ? GRID_ROWS : int'(row_bound);
        cb = (col_bound > GRID_COLS) ? GRID_COLS : int'(col_bound);
        if (r == 0)
            return STAT_SOUTH;
        if (int'(r) + 1 >= rb)
            return STAT_NORTH;
        if (c == 0)
            return STAT_WEST;
        if (int'(c) + 1 >= cb)
            return STAT_EAST;
        return STAT_OK;
    endfunction

    // neighbor k in visiting order: north, south, west, east
    function automatic void neighbor(input int k, input logic [ROW_W-1:0] r,
                                     input logic [COL_W-1:0] c,
                                     output logic [ROW_W-1:0] nr,
                                     output logic [COL_W-1:0] nc,
                                     output logic [PMASK_W-1:0] bitm);
        nr = r;
        nc = c;
        case (2'(k))
            DIR_NORTH: begin
                nr = r + 1'b1;
                bitm = BIT_NORTH;
            end
            DIR_SOUTH: begin
                nr = r - 1'b1;
                bitm = BIT_SOUTH;
            end
            DIR_WEST: begin
                nc = c - 1'b1;
                bitm = BIT_WEST;
            end
            default: begin
                nc = c + 1'b1;
                bitm = BIT_EAST;
            end
        endcase
    endfunction

    // update the mirrors for one accepted request and queue the downslope results
    function automatic void predict_downslope(input request_t rq);
        logic [ROW_W-1:0]   nr;
        logic [COL_W-1:0]   nc;
        logic [PMASK_W-1:0] bitm;
        logic [AIDX_W-1:0]  idx;
        logic [ELEV_W-1:0]  ne;
        logic [STAT_W-1:0]  st;
        downslope_t         hit [4];
        downslope_t         res;
        int                 n;
        n = 0;
        res = '0;
        case (rq.kind)
            REQ_GRID: begin
                elev_mirror[{rq.row, rq.col}] = rq.elev;
                index_mirror[{rq.row, rq.col}] = rq.aidx;
            end
            REQ_ENTRY: active_mirror[rq.aidx] = rq.elev;
            REQ_QUERY: begin
                st = bound_status(rq.row, rq.col);
                if (st != STAT_OK) begin
                    res.status = st;
                    res.last = 1'b1;
                    downslope_q.push_back(res);
                end else begin
                    for (int k = 0; k < 4; k++) begin
                        neighbor(k, rq.row, rq.col, nr, nc, bitm);
                        if ((rq.pmask & bitm) == '0) begin
                            // active cells take their elevation from the active list
                            idx = index_mirror[{nr, nc}];
                            ne = (idx == '0) ? elev_mirror[{nr, nc}] : active_mirror[idx];
                            if ($signed(rq.elev) > $signed(ne)) begin
                                hit[n] = '0;
                                hit[n].status = STAT_OK;
                                hit[n].nvalid = 1'b1;
                                hit[n].nrow = nr;
                                hit[n].ncol = nc;
                                hit[n].nelev = ne;
                                n++;
                            end
                        end
                    end
                    if (n == 0) begin
                        res.last = 1'b1;
                        downslope_q.push_back(res);
                    end else begin
                        for (int j = 0; j < n; j++) begin
                            hit[j].count = CNT_W'(n);
                            hit[j].last = (j == n - 1);
                            downslope_q.push_back(hit[j]);
                        end
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // idle length: mostly short, a few long, with calm stretches of none
    function automatic int idle_len(inout int calm);
        int p;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        p = $urandom_range(0, 99);
        if (p < 3) begin
            calm = $urandom_range(15, 40);
            return 0;
        end
        if (p < 45)
            return 0;
        if (p < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // elevations: extremes, a narrow band around zero for ties, or any value
    function automatic logic [ELEV_W-1:0] rand_elev();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2, 3: return $urandom;
            default: return 32'(int'($urandom_range(0, 32)) - 16);
        endcase
    endfunction

    // coordinate on or near an edge of the bounds or the grid
    function automatic logic [7:0] edge_pick(input int b);
        int v;
        case ($urandom_range(0, 4))
            0: v = 0;
            1: v = 1;
            2: v = b - 2;
            3: v = b - 1;
            default: v = 255;
        endcase
        if (v < 0)
            v = 0;
        return 8'(v);
    endfunction

    task automatic push_req(input logic [REQ_W-1:0] kind, input logic [ROW_W-1:0] r,
                            input logic [COL_W-1:0] c, input logic [ELEV_W-1:0] e,
                            input logic [AIDX_W-1:0] ai, input logic [PMASK_W-1:0] pm);
        request_t rq;
        rq = '{kind: kind, row: r, col: c, elev: e, aidx: ai, pmask: pm};
        request_q.push_back(rq);
        if (kind == REQ_GRID)
            cell_loaded[{r, c}] = 1'b1;
        if (kind == REQ_ENTRY)
            entry_loaded[ai] = 1'b1;
        if (kind != REQ_SKIP)
            feed_count++;
    endtask

    // grid write with a fresh elevation; an active cell gets its entry loaded too
    task automatic load_cell(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c);
        logic [AIDX_W-1:0] ai;
        if ($urandom_range(0, 4) < 3)
            ai = '0;
        else if ($urandom_range(0, 3) == 0)
            ai = AIDX_W'($urandom_range(1, 1023));
        else
            ai = AIDX_W'($urandom_range(1, 8));
        push_req(REQ_GRID, r, c, rand_elev(), ai, PMASK_W'($urandom));
        if (ai != '0 && (!entry_loaded[ai] || $urandom_range(0, 2) == 0))
            push_req(REQ_ENTRY, ROW_W'($urandom), COL_W'($urandom), rand_elev(), ai,
                     PMASK_W'($urandom));
    endtask

    // wait until every request is in and every result is out, then let the block drain
    task automatic settle();
        @(negedge aclk);
        while (request_q.size() != 0 || s_tvalid || downslope_q.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // request driver
    request_t cur_req;
    int tx_gap  = 0;
    int tx_calm = 0;

    always @(posedge aclk) begin : feeder
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_downslope(cur_req);
                sent_count++;
                if (cur_req.kind == REQ_QUERY)
                    queries_sent++;
                tx_gap = idle_len(tx_calm);
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (request_q.size() != 0) begin
                    cur_req = request_q.pop_front();
                    s_tdata <= {2'b00, cur_req.pmask, cur_req.aidx, cur_req.elev,
                                cur_req.col, cur_req.row};
                    s_tuser <= cur_req.kind;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, $signed(want), $signed(got));
            err_count++;
        end
    endtask

    // result monitor and receiver stalls
    int rx_stall  = 0;
    int rx_calm   = 0;
    int hold_left = 0;
    int hold_seen = 0;

    always @(posedge aclk) begin : collector
        downslope_t got;
        downslope_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.status = m_tdata[2:0];
                got.nrow   = m_tdata[10:3];
                got.ncol   = m_tdata[18:11];
                got.nelev  = m_tdata[50:19];
                got.count  = m_tdata[53:51];
                got.nvalid = m_tuser;
                got.last   = m_tlast;
                results_seen++;
                if (downslope_q.size() == 0) begin
                    $error("result transaction with nothing expected: status %0d", got.status);
                    err_count++;
                end else begin
                    want = downslope_q.pop_front();
                    if (want.nvalid)
                        hits_seen++;
                    else if (want.status == STAT_OK)
                        empty_seen++;
                    else
                        off_seen++;
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("neighbor_valid", 32'(want.nvalid), 32'(got.nvalid));
                    check_field("nbr_row", 32'(want.nrow), 32'(got.nrow));
                    check_field("nbr_col", 32'(want.ncol), 32'(got.ncol));
                    check_field("nbr_elev", want.nelev, got.nelev);
                    check_field("neighbor_count", 32'(want.count), 32'(got.count));
                    check_field("last", 32'(want.last), 32'(got.last));
                end
            end
            // a long hold-off when asked, otherwise random stalls
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (hold_seen != hold_asked) begin
                hold_seen = hold_asked;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                rx_stall = idle_len(rx_calm);
            end
        end
    end

    // watchdog
    initial begin
        #6_000_000;
        $display("tb_downslope_neighbor_finder: done, errors");
        $finish;
    end

    // stimulus
    initial begin : stimulus
        int rb;
        int cb;
        int win_r;
        int win_c;
        int target;
        int pick;
        logic [ROW_W-1:0]   r;
        logic [COL_W-1:0]   c;
        logic [ROW_W-1:0]   nr;
        logic [COL_W-1:0]   nc;
        logic [PMASK_W-1:0] pm;
        logic [PMASK_W-1:0] bitm;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: a centre at (5,5) with one neighbor of each flavor
        push_req(REQ_GRID, 6, 5, -32'sd100, 0, 0);
        push_req(REQ_ENTRY, 0, 0, 32'h8000_0000, 1023, 0);
        push_req(REQ_GRID, 4, 5, 32'h7fff_ffff, 1023, 0);
        push_req(REQ_ENTRY, 0, 0, 10, 1, 0);
        push_req(REQ_GRID, 5, 4, -32'sd5, 1, 0);
        push_req(REQ_GRID, 5, 6, 7, 0, 0);
        push_req(REQ_QUERY, 5, 5, 8, 0, 0);
        // tie with the east cell does not count
        push_req(REQ_QUERY, 5, 5, 7, 0, 0);
        push_req(REQ_QUERY, 5, 5, 32'h8000_0000, 0, 0);
        push_req(REQ_QUERY, 5, 5, 32'h7fff_ffff, 0, 4'hf);
        push_req(REQ_QUERY, 5, 5, 32'h7fff_ffff, 0, 0);
        push_req(REQ_QUERY, 5, 5, 32'h7fff_ffff, 0, BIT_EAST | BIT_WEST);
        // off-grid on each side, and precedence at the corners
        push_req(REQ_QUERY, 0, 5, 0, 0, 0);
        push_req(REQ_QUERY, 255, 5, 0, 0, 0);
        push_req(REQ_QUERY, 5, 0, 0, 0, 0);
        push_req(REQ_QUERY, 5, 255, 0, 0, 0);
        push_req(REQ_QUERY, 0, 0, 0, 0, 0);
        push_req(REQ_QUERY, 255, 0, 0, 0, 0);
        push_req(REQ_SKIP, 8'hff, 8'hff, 32'hffff_ffff, 10'h3ff, 4'hf);
        // rewritten active entry changes the west answer
        push_req(REQ_ENTRY, 0, 0, -32'sd1000, 1, 0);
        push_req(REQ_QUERY, 5, 5, 8, 0, BIT_NORTH);
        push_req(REQ_GRID, 255, 255, 32'hffff_ffff, 1023, 4'hf);

        for (int p = 0; p < NUM_PHASES; p++) begin
            // new bounds only while the block is idle
            if (p != 0) begin
                settle();
                @(posedge aclk);
                cfg_we <= 1'b1;
                cfg_addr <= REG_NUM_ROWS;
                cfg_wdata <= BOUND_W'(phase_rows[p]);
                @(posedge aclk);
                cfg_addr <= REG_NUM_COLS;
                cfg_wdata <= BOUND_W'(phase_cols[p]);
                @(posedge aclk);
                cfg_we <= 1'b0;
                row_bound = BOUND_W'(phase_rows[p]);
                col_bound = BOUND_W'(phase_cols[p]);
                @(negedge aclk);
            end
            if (p == 1 || p == 6)
                hold_asked++;

            rb = (row_bound > GRID_ROWS) ? GRID_ROWS : int'(row_bound);
            cb = (col_bound > GRID_COLS) ? GRID_COLS : int'(col_bound);
            win_r = (rb >= 3) ? $urandom_range(1, rb - 2) : 1;
            win_c = (cb >= 3) ? $urandom_range(1, cb - 2) : 1;

            target = feed_count + phase_feed[p];
            while (feed_count < target) begin
                pick = $urandom_range(0, 99);
                if (pick < 5) begin
                    push_req(REQ_SKIP, ROW_W'($urandom), COL_W'($urandom), $urandom,
                             AIDX_W'($urandom), PMASK_W'($urandom));
                end else if (pick < 12) begin
                    push_req(REQ_ENTRY, ROW_W'($urandom), COL_W'($urandom), rand_elev(),
                             AIDX_W'($urandom), PMASK_W'($urandom));
                end else if (pick < 18) begin
                    load_cell(ROW_W'($urandom), COL_W'($urandom));
                end else begin
                    // query centre: mostly in a small window so loaded cells get reused
                    pick = $urandom_range(0, 99);
                    if (pick < 70 && rb >= 3 && cb >= 3) begin
                        r = ROW_W'(win_r + $urandom_range(0, 4));
                        c = COL_W'(win_c + $urandom_range(0, 4));
                        if (int'(r) > rb - 2)
                            r = ROW_W'(rb - 2);
                        if (int'(c) > cb - 2)
                            c = COL_W'(cb - 2);
                    end else if (pick < 88) begin
                        r = edge_pick(rb);
                        c = edge_pick(cb);
                    end else begin
                        r = ROW_W'($urandom);
                        c = COL_W'($urandom);
                    end
                    pm = ($urandom_range(0, 2) == 0) ? PMASK_W'($urandom) : '0;
                    // every neighbor the query will read must hold data first
                    if (bound_status(r, c) == STAT_OK) begin
                        for (int k = 0; k < 4; k++) begin
                            neighbor(k, r, c, nr, nc, bitm);
                            if ((pm & bitm) == '0 &&
                                (!cell_loaded[{nr, nc}] || $urandom_range(0, 3) == 0))
                                load_cell(nr, nc);
                        end
                    end
                    push_req(REQ_QUERY, r, c, rand_elev(), AIDX_W'($urandom), pm);
                end
            end
        end

        // drain and finish
        settle();
        $display("covered %0d requests, %0d of them queries, over %0d bound settings",
                 sent_count, queries_sent, NUM_PHASES);
        $display("saw %0d results: %0d downslope neighbors, %0d empty, %0d off grid",
                 results_seen, hits_seen, empty_seen, off_seen);
        if (err_count == 0)
            $display("tb_downslope_neighbor_finder: done, clean");
        else
            $display("tb_downslope_neighbor_finder: done, errors");
        $finish;
    end

endmodule
